[rtl/core/value_to_spectral_rgb_core_assert.svh]
// assertion macros for the spectral color core
`ifndef VALUE_TO_SPECTRAL_RGB_CORE_ASSERT_SVH
`define VALUE_TO_SPECTRAL_RGB_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VSRGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain check of a condition at every edge out of reset
`define VSRGB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

[rtl/core/vsrgb_pkg.sv]
package vsrgb_pkg;

    // unity in Q1.10
    localparam logic [10:0] CHAN_ONE = 11'd1024;

    // wavelength marks in Q10.6 nm
    localparam logic [15:0] L_380 = 16'd24320;
    localparam logic [15:0] L_420 = 16'd26880;
    localparam logic [15:0] L_440 = 16'd28160;
    localparam logic [15:0] L_490 = 16'd31360;
    localparam logic [15:0] L_510 = 16'd32640;
    localparam logic [15:0] L_580 = 16'd37120;
    localparam logic [15:0] L_645 = 16'd41280;
    localparam logic [15:0] L_700 = 16'd44800;
    localparam logic [15:0] L_780 = 16'd49920;

    // falloff offsets, 1024 factored out of both sides
    localparam logic [16:0] FALL_HI_BASE = 17'd15360;
    localparam logic [16:0] FALL_LO_BASE = 17'd7680;

    // constant divisors and their floor reciprocals at 2^20
    localparam int RCP_SHIFT = 20;
    localparam logic [6:0] DIV_20 = 7'd20;
    localparam logic [6:0] DIV_25 = 7'd25;
    localparam logic [6:0] DIV_50 = 7'd50;
    localparam logic [6:0] DIV_60 = 7'd60;
    localparam logic [6:0] DIV_65 = 7'd65;
    localparam logic [6:0] DIV_70 = 7'd70;
    localparam logic [15:0] RCP_20 = 16'((1 << RCP_SHIFT) / 20);
    localparam logic [15:0] RCP_25 = 16'((1 << RCP_SHIFT) / 25);
    localparam logic [15:0] RCP_50 = 16'((1 << RCP_SHIFT) / 50);
    localparam logic [15:0] RCP_60 = 16'((1 << RCP_SHIFT) / 60);
    localparam logic [15:0] RCP_65 = 16'((1 << RCP_SHIFT) / 65);
    localparam logic [15:0] RCP_70 = 16'((1 << RCP_SHIFT) / 70);

    // register indexes
    localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
    localparam logic [2:0] REG_INV_START  = 3'd2;
    localparam logic [2:0] REG_INV_END    = 3'd3;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd4;

    // register reset values
    localparam logic [15:0] INV_START_RESET  = 16'd44150;
    localparam logic [15:0] INV_END_RESET    = 16'd21509;
    localparam logic [11:0] BRIGHTNESS_RESET = 12'd256;

    // spectral bands
    typedef enum logic [2:0] {
        BAND_VIOLET = 3'd0,
        BAND_BLUE   = 3'd1,
        BAND_CYAN   = 3'd2,
        BAND_GREEN  = 3'd3,
        BAND_YELLOW = 3'd4,
        BAND_RED    = 3'd5
    } band_t;

    // control that travels beside the data
    typedef struct packed {
        logic vld;
        logic black;
    } flow_t;

endpackage

[rtl/core/value_to_spectral_rgb_core.sv]
// Spectral color mapper: takes one signed sample per clock on start and, at the end of the
// pipeline, shows the red, green and blue levels for exactly one cycle under done. busy
// stays low, so a new sample may be given in every cycle; the pipeline is made of two
// bit-per-stage pipelined dividers (SAMPLE_BITS + 16 stages for the range normalization,
// 31 stages for the wavelength reciprocal) plus the stages of band, falloff, gamma rom
// and gain logic. done cannot be held off: a result must be taken in the cycle it is
// shown. Registers may be written only while no sample is in flight.
`include "value_to_spectral_rgb_core_assert.svh"

module value_to_spectral_rgb_core #(
    parameter int SAMPLE_BITS     = 16,
    parameter int GAMMA_ADDR_BITS = 10
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    output logic                                          busy,
    input  logic signed [SAMPLE_BITS-1:0]                 sample,
    input  logic                                          cfg_write,
    input  logic [2:0]                                    cfg_index,
    input  logic [((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16)-1:0] cfg_data,
    output logic                                          done,
    output logic [7:0]                                    red_level,
    output logic [7:0]                                    green_level,
    output logic [7:0]                                    blue_level
);

    localparam int NUM1_BITS = SAMPLE_BITS + 16;
    localparam int MAG_BITS  = (NUM1_BITS > 41) ? 41 : NUM1_BITS;
    localparam logic [63:0] MAP_SAT = 64'd1 << 40;
    localparam logic [SAMPLE_BITS-1:0] HIGH_RESET =
        (SAMPLE_BITS > 16) ? SAMPLE_BITS'(32767) : {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // configuration registers
    logic signed [SAMPLE_BITS-1:0] range_low_reg;
    logic signed [SAMPLE_BITS-1:0] range_high_reg;
    logic [15:0]                   inv_start_reg;
    logic [15:0]                   inv_end_reg;
    logic [11:0]                   brightness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= HIGH_RESET;
            inv_start_reg  <= vsrgb_pkg::INV_START_RESET;
            inv_end_reg    <= vsrgb_pkg::INV_END_RESET;
            brightness_reg <= vsrgb_pkg::BRIGHTNESS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                vsrgb_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_data[SAMPLE_BITS-1:0];
                vsrgb_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_data[SAMPLE_BITS-1:0];
                vsrgb_pkg::REG_INV_START:  inv_start_reg  <= cfg_data[15:0];
                vsrgb_pkg::REG_INV_END:    inv_end_reg    <= cfg_data[15:0];
                vsrgb_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data[11:0];
                default:                   range_low_reg  <= range_low_reg;
            endcase
        end
    end

    // no stall source, a transaction is taken every cycle
    assign busy = 1'b0;

    // offset and span as sign and magnitude
    logic signed [SAMPLE_BITS:0] diff_next;
    logic signed [SAMPLE_BITS:0] span_next;
    logic [SAMPLE_BITS-1:0]      diff_mag;
    logic [SAMPLE_BITS-1:0]      span_mag;
    logic                        f_vld_reg;
    logic [NUM1_BITS-1:0]        f_num_reg;
    logic [SAMPLE_BITS-1:0]      f_den_reg;
    logic [1:0]                  f_tag_reg;

    assign diff_next = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(range_low_reg);
    assign span_next = (SAMPLE_BITS+1)'(range_high_reg) - (SAMPLE_BITS+1)'(range_low_reg);
    assign diff_mag  = diff_next[SAMPLE_BITS] ? SAMPLE_BITS'(-diff_next) : SAMPLE_BITS'(diff_next);
    assign span_mag  = span_next[SAMPLE_BITS] ? SAMPLE_BITS'(-span_next) : SAMPLE_BITS'(span_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        f_num_reg <= {diff_mag, 16'b0};
        f_den_reg <= span_mag;
        f_tag_reg <= {diff_next[SAMPLE_BITS] ^ span_next[SAMPLE_BITS], span_next == '0};
    end

    // normalization divider
    logic                 d1_vld;
    logic [NUM1_BITS-1:0] d1_quo;
    logic [1:0]           d1_tag;

    vsrgb_div #(
        .NUM_BITS (NUM1_BITS),
        .DEN_BITS (SAMPLE_BITS),
        .TAG_BITS (2)
    ) u_map_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (f_vld_reg),
        .in_num  (f_num_reg),
        .in_den  (f_den_reg),
        .in_tag  (f_tag_reg),
        .out_vld (d1_vld),
        .out_quo (d1_quo),
        .out_tag (d1_tag)
    );

    // saturate and scale by the reciprocal span
    logic signed [16:0]     wdiff;
    logic [15:0]            wdiff_mag;
    logic [MAG_BITS-1:0]    m_mag;
    logic [MAG_BITS+15:0]   m_prod_next;
    logic                   m_vld_reg;
    logic [MAG_BITS+15:0]   m_prod_reg;
    logic                   m_qneg_reg;
    logic                   m_zero_reg;

    assign wdiff       = $signed({1'b0, inv_start_reg}) - $signed({1'b0, inv_end_reg});
    assign wdiff_mag   = wdiff[16] ? 16'(-wdiff) : wdiff[15:0];
    assign m_mag       = (64'(d1_quo) > MAP_SAT) ? MAG_BITS'(MAP_SAT) : MAG_BITS'(d1_quo);
    assign m_prod_next = (MAG_BITS+16)'(m_mag) * (MAG_BITS+16)'(wdiff_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg <= m_prod_next;
        m_qneg_reg <= d1_tag[1] ^ wdiff[16];
        m_zero_reg <= d1_tag[0];
    end

    // blend of reciprocals, black when not a usable divisor
    logic [MAG_BITS-1:0] q_mag;
    logic [MAG_BITS:0]   bl_sum;
    logic                b_black_next;
    logic                b_vld_reg;
    logic                b_black_reg;
    logic [15:0]         b_den_reg;

    assign q_mag  = m_prod_reg[MAG_BITS+15:16];
    assign bl_sum = (MAG_BITS+1)'(inv_start_reg) + (MAG_BITS+1)'(q_mag);
    assign b_black_next = m_zero_reg |
        (m_qneg_reg ? ((bl_sum >= (MAG_BITS+1)'(65536)) || (bl_sum == '0))
                    : (q_mag >= MAG_BITS'(inv_start_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg   <= 1'b0;
            b_black_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg   <= m_vld_reg;
            b_black_reg <= b_black_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_den_reg <= m_qneg_reg ? bl_sum[15:0] : (inv_start_reg - q_mag[15:0]);
    end

    // wavelength divider
    logic        d2_vld;
    logic [30:0] d2_quo;
    logic        d2_black;

    vsrgb_div #(
        .NUM_BITS (31),
        .DEN_BITS (16),
        .TAG_BITS (1)
    ) u_wave_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (b_vld_reg),
        .in_num  (31'h4000_0000),
        .in_den  (b_den_reg),
        .in_tag  (b_black_reg),
        .out_vld (d2_vld),
        .out_quo (d2_quo),
        .out_tag (d2_black)
    );

    // band and falloff
    vsrgb_pkg::flow_t band_in_flow;
    vsrgb_pkg::flow_t band_flow;
    logic [10:0]      red_chan;
    logic [10:0]      green_chan;
    logic [10:0]      blue_chan;
    logic [10:0]      falloff;

    assign band_in_flow.vld   = d2_vld;
    assign band_in_flow.black = d2_black;

    vsrgb_band u_band (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_flow    (band_in_flow),
        .wave       (d2_quo),
        .out_flow   (band_flow),
        .red_chan   (red_chan),
        .green_chan (green_chan),
        .blue_chan  (blue_chan),
        .falloff    (falloff)
    );

    // gamma and gain per channel
    logic [7:0] red_lvl;
    logic [7:0] green_lvl;
    logic [7:0] blue_lvl;

    vsrgb_level #(.GAMMA_ADDR_BITS (GAMMA_ADDR_BITS)) u_red (
        .clk        (clk),
        .chan       (red_chan),
        .falloff    (falloff),
        .brightness (brightness_reg),
        .level      (red_lvl)
    );

    vsrgb_level #(.GAMMA_ADDR_BITS (GAMMA_ADDR_BITS)) u_green (
        .clk        (clk),
        .chan       (green_chan),
        .falloff    (falloff),
        .brightness (brightness_reg),
        .level      (green_lvl)
    );

    vsrgb_level #(.GAMMA_ADDR_BITS (GAMMA_ADDR_BITS)) u_blue (
        .clk        (clk),
        .chan       (blue_chan),
        .falloff    (falloff),
        .brightness (brightness_reg),
        .level      (blue_lvl)
    );

    // control delay matching the level stages
    vsrgb_pkg::flow_t flow_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                flow_reg[i] <= '0;
            end
        end
        else
        begin
            flow_reg[0] <= band_flow;
            for (int i = 1; i < 4; i++)
            begin
                flow_reg[i] <= flow_reg[i-1];
            end
        end
    end

    // result transaction, black forces zero
    logic       done_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= flow_reg[3].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= flow_reg[3].black ? 8'd0 : red_lvl;
        green_reg <= flow_reg[3].black ? 8'd0 : green_lvl;
        blue_reg  <= flow_reg[3].black ? 8'd0 : blue_lvl;
    end

    assign done        = done_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

    // checks
    logic chan_ok;

    assign chan_ok = (red_chan <= vsrgb_pkg::CHAN_ONE) && (green_chan <= vsrgb_pkg::CHAN_ONE)
        && (blue_chan <= vsrgb_pkg::CHAN_ONE) && (falloff <= vsrgb_pkg::CHAN_ONE);

    `VSRGB_ASSERT_NOW(a_den_nonzero, b_vld_reg && !b_black_reg, b_den_reg != 16'd0, "zero divisor")
    `VSRGB_ASSERT_NOW(a_chan_bound, band_flow.vld && !band_flow.black, chan_ok, "above unity")
    `VSRGB_ASSERT_ALWAYS(a_out_latency, done == $past(band_flow.vld, 5), "done out of step")

endmodule

[rtl/core/vsrgb_div.sv]
module vsrgb_div #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 16,
    parameter int TAG_BITS = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic [NUM_BITS-1:0] in_num,
    input  logic [DEN_BITS-1:0] in_den,
    input  logic [TAG_BITS-1:0] in_tag,
    output logic                out_vld,
    output logic [NUM_BITS-1:0] out_quo,
    output logic [TAG_BITS-1:0] out_tag
);

    // one quotient bit per stage, dividend shifts out as quotient shifts in
    logic [NUM_BITS-1:0] vld_reg;
    logic [DEN_BITS-1:0] rem_reg [NUM_BITS];
    logic [NUM_BITS-1:0] quo_reg [NUM_BITS];
    logic [DEN_BITS-1:0] den_reg [NUM_BITS];
    logic [TAG_BITS-1:0] tag_reg [NUM_BITS];

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
        logic                vld_in;
        logic [DEN_BITS-1:0] rem_in;
        logic [NUM_BITS-1:0] quo_in;
        logic [DEN_BITS-1:0] den_in;
        logic [TAG_BITS-1:0] tag_in;
        logic [DEN_BITS:0]   trial;
        logic [DEN_BITS:0]   diff;
        logic                fits;

        if (k == 0) begin : g_first
            assign vld_in = in_vld;
            assign rem_in = '0;
            assign quo_in = in_num;
            assign den_in = in_den;
            assign tag_in = in_tag;
        end
        else begin : g_next
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        // trial subtract
        assign trial = {rem_in, quo_in[NUM_BITS-1]};
        assign diff  = trial - {1'b0, den_in};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            quo_reg[k] <= {quo_in[NUM_BITS-2:0], fits};
            den_reg[k] <= den_in;
            tag_reg[k] <= tag_in;
        end
    end

    assign out_vld = vld_reg[NUM_BITS-1];
    assign out_quo = quo_reg[NUM_BITS-1];
    assign out_tag = tag_reg[NUM_BITS-1];

endmodule

[rtl/core/vsrgb_band.sv]
module vsrgb_band (
    input  logic              clk,
    input  logic              rst_n,
    input  vsrgb_pkg::flow_t  in_flow,
    input  logic [30:0]       wave,
    output vsrgb_pkg::flow_t  out_flow,
    output logic [10:0]       red_chan,
    output logic [10:0]       green_chan,
    output logic [10:0]       blue_chan,
    output logic [10:0]       falloff
);

    logic [15:0]            l16;
    logic                   out_of_band;
    vsrgb_pkg::band_t       band_next;
    logic [16:0]            slope_n_next;
    logic [6:0]             slope_d_next;
    logic [15:0]            slope_r_next;
    logic                   fall_on_next;
    logic [16:0]            fall_n_next;
    logic [6:0]             fall_d_next;
    logic [15:0]            fall_r_next;

    vsrgb_pkg::flow_t       flow1_reg;
    vsrgb_pkg::flow_t       flow2_reg;
    vsrgb_pkg::band_t       band1_reg;
    vsrgb_pkg::band_t       band2_reg;
    logic [16:0]            slope_n1_reg;
    logic [6:0]             slope_d1_reg;
    logic [15:0]            slope_r1_reg;
    logic                   fall_on1_reg;
    logic [16:0]            fall_n1_reg;
    logic [6:0]             fall_d1_reg;
    logic [15:0]            fall_r1_reg;
    logic [16:0]            slope_n2_reg;
    logic [6:0]             slope_d2_reg;
    logic [12:0]            slope_est_reg;
    logic                   fall_on2_reg;
    logic [16:0]            fall_n2_reg;
    logic [6:0]             fall_d2_reg;
    logic [12:0]            fall_est_reg;
    logic [32:0]            slope_prod;
    logic [32:0]            fall_prod;
    logic [16:0]            slope_rem;
    logic [16:0]            fall_rem;
    logic [12:0]            slope_q;
    logic [12:0]            fall_q;
    logic [10:0]            slope_val;
    logic [10:0]            red_next;
    logic [10:0]            green_next;
    logic [10:0]            blue_next;

    assign l16 = wave[15:0];
    assign out_of_band = (wave < 31'(vsrgb_pkg::L_380)) || (wave > 31'(vsrgb_pkg::L_780));

    // band select and slope dividend
    always_comb
    begin
        band_next    = vsrgb_pkg::BAND_RED;
        slope_n_next = '0;
        slope_d_next = vsrgb_pkg::DIV_65;
        slope_r_next = vsrgb_pkg::RCP_65;
        if (l16 <= vsrgb_pkg::L_440)
        begin
            band_next    = vsrgb_pkg::BAND_VIOLET;
            slope_n_next = 17'({vsrgb_pkg::L_440 - l16, 4'b0000});
            slope_d_next = vsrgb_pkg::DIV_60;
            slope_r_next = vsrgb_pkg::RCP_60;
        end
        else if (l16 <= vsrgb_pkg::L_490)
        begin
            band_next    = vsrgb_pkg::BAND_BLUE;
            slope_n_next = 17'({l16 - vsrgb_pkg::L_440, 4'b0000});
            slope_d_next = vsrgb_pkg::DIV_50;
            slope_r_next = vsrgb_pkg::RCP_50;
        end
        else if (l16 <= vsrgb_pkg::L_510)
        begin
            band_next    = vsrgb_pkg::BAND_CYAN;
            slope_n_next = 17'({vsrgb_pkg::L_510 - l16, 4'b0000});
            slope_d_next = vsrgb_pkg::DIV_20;
            slope_r_next = vsrgb_pkg::RCP_20;
        end
        else if (l16 <= vsrgb_pkg::L_580)
        begin
            band_next    = vsrgb_pkg::BAND_GREEN;
            slope_n_next = 17'({l16 - vsrgb_pkg::L_510, 4'b0000});
            slope_d_next = vsrgb_pkg::DIV_70;
            slope_r_next = vsrgb_pkg::RCP_70;
        end
        else if (l16 <= vsrgb_pkg::L_645)
        begin
            band_next    = vsrgb_pkg::BAND_YELLOW;
            slope_n_next = 17'({vsrgb_pkg::L_645 - l16, 4'b0000});
        end
    end

    // edge falloff dividend
    always_comb
    begin
        fall_on_next = 1'b0;
        fall_n_next  = '0;
        fall_d_next  = vsrgb_pkg::DIV_25;
        fall_r_next  = vsrgb_pkg::RCP_25;
        if (l16 > vsrgb_pkg::L_700)
        begin
            fall_on_next = 1'b1;
            fall_n_next  = vsrgb_pkg::FALL_HI_BASE + 17'(7 * (vsrgb_pkg::L_780 - l16));
            fall_d_next  = vsrgb_pkg::DIV_50;
            fall_r_next  = vsrgb_pkg::RCP_50;
        end
        else if (l16 < vsrgb_pkg::L_420)
        begin
            fall_on_next = 1'b1;
            fall_n_next  = vsrgb_pkg::FALL_LO_BASE + 17'(7 * (l16 - vsrgb_pkg::L_380));
        end
    end

    // reciprocal estimates
    assign slope_prod = 33'(slope_n1_reg) * 33'(slope_r1_reg);
    assign fall_prod  = 33'(fall_n1_reg) * 33'(fall_r1_reg);

    // one correction step
    assign slope_rem = slope_n2_reg - 17'(slope_est_reg * slope_d2_reg);
    assign fall_rem  = fall_n2_reg - 17'(fall_est_reg * fall_d2_reg);
    assign slope_q   = slope_est_reg + 13'(slope_rem >= 17'(slope_d2_reg));
    assign fall_q    = fall_est_reg + 13'(fall_rem >= 17'(fall_d2_reg));
    assign slope_val = slope_q[10:0];

    // channel assembly
    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        unique case (band2_reg)
            vsrgb_pkg::BAND_VIOLET:
            begin
                red_next  = slope_val;
                blue_next = vsrgb_pkg::CHAN_ONE;
            end
            vsrgb_pkg::BAND_BLUE:
            begin
                green_next = slope_val;
                blue_next  = vsrgb_pkg::CHAN_ONE;
            end
            vsrgb_pkg::BAND_CYAN:
            begin
                green_next = vsrgb_pkg::CHAN_ONE;
                blue_next  = slope_val;
            end
            vsrgb_pkg::BAND_GREEN:
            begin
                red_next   = slope_val;
                green_next = vsrgb_pkg::CHAN_ONE;
            end
            vsrgb_pkg::BAND_YELLOW:
            begin
                red_next   = vsrgb_pkg::CHAN_ONE;
                green_next = slope_val;
            end
            vsrgb_pkg::BAND_RED:
            begin
                red_next = vsrgb_pkg::CHAN_ONE;
            end
            default:
            begin
                red_next = '0;
            end
        endcase
    end

    // control through the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow1_reg <= '0;
            flow2_reg <= '0;
            out_flow  <= '0;
        end
        else
        begin
            flow1_reg.vld   <= in_flow.vld;
            flow1_reg.black <= in_flow.black | out_of_band;
            flow2_reg       <= flow1_reg;
            out_flow        <= flow2_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        band1_reg     <= band_next;
        slope_n1_reg  <= slope_n_next;
        slope_d1_reg  <= slope_d_next;
        slope_r1_reg  <= slope_r_next;
        fall_on1_reg  <= fall_on_next;
        fall_n1_reg   <= fall_n_next;
        fall_d1_reg   <= fall_d_next;
        fall_r1_reg   <= fall_r_next;

        band2_reg     <= band1_reg;
        slope_n2_reg  <= slope_n1_reg;
        slope_d2_reg  <= slope_d1_reg;
        slope_est_reg <= slope_prod[32:20];
        fall_on2_reg  <= fall_on1_reg;
        fall_n2_reg   <= fall_n1_reg;
        fall_d2_reg   <= fall_d1_reg;
        fall_est_reg  <= fall_prod[32:20];

        red_chan      <= red_next;
        green_chan    <= green_next;
        blue_chan     <= blue_next;
        falloff       <= fall_on2_reg ? fall_q[10:0] : vsrgb_pkg::CHAN_ONE;
    end

endmodule

[rtl/core/vsrgb_level.sv]
module vsrgb_level #(
    parameter int GAMMA_ADDR_BITS = 10
) (
    input  logic        clk,
    input  logic [10:0] chan,
    input  logic [10:0] falloff,
    input  logic [11:0] brightness,
    output logic [7:0]  level
);

    localparam int ROM_SIZE = (1 << GAMMA_ADDR_BITS) + 1;

    // gamma 0.8 entries, exact rounding by comparing fifth powers
    function automatic logic [ROM_SIZE*11-1:0] gamma_fill();
        logic [ROM_SIZE*11-1:0] tbl;
        logic [63:0] y;
        logic [63:0] i4;
        logic [63:0] k;
        logic [63:0] t;
        logic        go;
        tbl = '0;
        y   = '0;
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            i4 = 64'(i) * 64'(i) * 64'(i) * 64'(i);
            k  = i4 << (55 - 4 * GAMMA_ADDR_BITS);
            go = 1'b1;
            while (go && (y < 64'd1024))
            begin
                t = 64'd2 * (y + 64'd1) - 64'd1;
                if (t * t * t * t * t <= k)
                    y = y + 64'd1;
                else
                    go = 1'b0;
            end
            tbl[i*11 +: 11] = 11'(y);
        end
        return tbl;
    endfunction

    localparam logic [ROM_SIZE*11-1:0] GAMMA_ROM = gamma_fill();

    logic [21:0]                  prod;
    logic [10+GAMMA_ADDR_BITS:0]  cw;
    logic [GAMMA_ADDR_BITS:0]     addr_reg;
    logic [10:0]                  gamma_reg;
    logic [22:0]                  gain_reg;
    logic [30:0]                  scaled;

    // falloff product and rom address
    assign prod = 22'(chan) * 22'(falloff);
    assign cw   = {prod[20:10], {GAMMA_ADDR_BITS{1'b0}}};

    // times 255 as shift and subtract
    assign scaled = {gain_reg, 8'b0} - 31'(gain_reg);

    always_ff @(posedge clk)
    begin
        addr_reg  <= cw[10+GAMMA_ADDR_BITS:10];
        gamma_reg <= GAMMA_ROM[addr_reg*11 +: 11];
        gain_reg  <= 23'(gamma_reg) * 23'(brightness);
        level     <= (scaled[30:18] > 13'd255) ? 8'd255 : scaled[25:18];
    end

endmodule

[tb/tb_value_to_spectral_rgb_core.sv]
module tb_value_to_spectral_rgb_core;

    localparam int LATENCY = 16 + 57;
    localparam int STALL_LIMIT = 4000;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int ROM_LAST = 1024;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_WRITE,
        OP_SETTLE
    } op_t;

    typedef struct {
        op_t         op;
        logic [2:0]  idx;
        logic [15:0] data;
        int          gap;
    } job_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] sample;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               done;
    logic [7:0]         red_level;
    logic [7:0]         green_level;
    logic [7:0]         blue_level;

    job_t   job_q[$];
    pixel_t pixel_q[$];
    int     gap_left;
    int     mismatches = 0;
    int     stall_count = 0;
    logic   dense;

    // predictor copy of the register file
    longint mdl_low = 0;
    longint mdl_high = 32767;
    longint mdl_inv_start = longint'(vsrgb_pkg::INV_START_RESET);
    longint mdl_inv_end = longint'(vsrgb_pkg::INV_END_RESET);
    longint mdl_gain = longint'(vsrgb_pkg::BRIGHTNESS_RESET);
    longint gamma_tab[0:ROM_LAST];

    value_to_spectral_rgb_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sample      (sample),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one channel through falloff, gamma and gain
    function automatic logic [7:0] channel_level(longint chan, longint fall);
        longint c;
        longint v;
        c = (chan * fall) / 1024;
        if (c > ROM_LAST)
            c = ROM_LAST;
        v = (gamma_tab[c] * mdl_gain * 255) >>> 18;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // expected pixel for one sample under the current registers
    function automatic pixel_t spectral_pixel(logic signed [15:0] smp);
        pixel_t px;
        longint x, rng, m, q, bl, wl;
        longint r, g, b, fall;
        px = '{8'd0, 8'd0, 8'd0};
        r = 0;
        g = 0;
        b = 0;
        fall = 1024;
        x = smp;
        rng = mdl_high - mdl_low;
        if (rng == 0)
            return px;
        m = ((x - mdl_low) * 65536) / rng;
        if (m > (64'sd1 <<< 40))
            m = 64'sd1 <<< 40;
        if (m < -(64'sd1 <<< 40))
            m = -(64'sd1 <<< 40);
        q = (m * (mdl_inv_start - mdl_inv_end)) / 65536;
        bl = mdl_inv_start - q;
        if (bl <= 0)
            return px;
        wl = (64'sd1 <<< 30) / bl;
        if (wl < longint'(vsrgb_pkg::L_380) || wl > longint'(vsrgb_pkg::L_780))
            return px;
        // piecewise bands, first match wins
        if (wl <= longint'(vsrgb_pkg::L_440))
        begin
            r = ((longint'(vsrgb_pkg::L_440) - wl) * 1024) / (60 * 64);
            b = 1024;
        end
        else if (wl <= longint'(vsrgb_pkg::L_490))
        begin
            g = ((wl - longint'(vsrgb_pkg::L_440)) * 1024) / (50 * 64);
            b = 1024;
        end
        else if (wl <= longint'(vsrgb_pkg::L_510))
        begin
            g = 1024;
            b = ((longint'(vsrgb_pkg::L_510) - wl) * 1024) / (20 * 64);
        end
        else if (wl <= longint'(vsrgb_pkg::L_580))
        begin
            r = ((wl - longint'(vsrgb_pkg::L_510)) * 1024) / (70 * 64);
            g = 1024;
        end
        else if (wl <= longint'(vsrgb_pkg::L_645))
        begin
            r = 1024;
            g = ((longint'(vsrgb_pkg::L_645) - wl) * 1024) / (65 * 64);
        end
        else
        begin
            r = 1024;
        end
        // edge falloff
        if (wl > longint'(vsrgb_pkg::L_700))
            fall = (3 * 1024 * 80 * 64 + 7 * 1024 * (longint'(vsrgb_pkg::L_780) - wl))
                   / (10 * 80 * 64);
        else if (wl < longint'(vsrgb_pkg::L_420))
            fall = (3 * 1024 * 40 * 64 + 7 * 1024 * (wl - longint'(vsrgb_pkg::L_380)))
                   / (10 * 40 * 64);
        px.red = channel_level(r, fall);
        px.green = channel_level(g, fall);
        px.blue = channel_level(b, fall);
        return px;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (dense || p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic add_sample(logic [15:0] v);
        job_q.push_back('{OP_SAMPLE, 3'd0, v, pick_gap()});
    endtask

    task automatic add_write(logic [2:0] idx, logic [15:0] v);
        job_q.push_back('{OP_WRITE, idx, v, 0});
    endtask

    task automatic add_settle();
        job_q.push_back('{OP_SETTLE, 3'd0, 16'd0, 0});
    endtask

    task automatic add_config(logic [15:0] lo, logic [15:0] hi, logic [15:0] is,
                              logic [15:0] ie, logic [15:0] gain);
        add_write(vsrgb_pkg::REG_RANGE_LOW, lo);
        add_write(vsrgb_pkg::REG_RANGE_HIGH, hi);
        add_write(vsrgb_pkg::REG_INV_START, is);
        add_write(vsrgb_pkg::REG_INV_END, ie);
        add_write(vsrgb_pkg::REG_BRIGHTNESS, gain);
    endtask

    // samples mostly inside the configured range, some anywhere
    task automatic add_random_run(int n, int lo, int hi);
        int a;
        int z;
        a = (lo < hi) ? lo : hi;
        z = (lo < hi) ? hi : lo;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                dense = ($urandom_range(3) == 0);
            if ($urandom_range(99) < 75)
                add_sample(16'($urandom_range(z - a) + a));
            else
                add_sample(16'($urandom));
            if (i == n / 2)
                add_settle();
        end
        dense = 1'b0;
    endtask

    // driver: accepts, updates predictor, presents next transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            sample <= '0;
            cfg_write <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                pixel_q.push_back(spectral_pixel(sample));
            if (cfg_write)
            begin
                case (cfg_index)
                    vsrgb_pkg::REG_RANGE_LOW:  mdl_low = longint'(signed'(cfg_data));
                    vsrgb_pkg::REG_RANGE_HIGH: mdl_high = longint'(signed'(cfg_data));
                    vsrgb_pkg::REG_INV_START:  mdl_inv_start = cfg_data;
                    vsrgb_pkg::REG_INV_END:    mdl_inv_end = cfg_data;
                    vsrgb_pkg::REG_BRIGHTNESS: mdl_gain = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (start && busy)
            begin
                // hold the pending transaction
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                cfg_write <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (job_q.size() == 0)
            begin
                start <= 1'b0;
                cfg_write <= 1'b0;
            end
            else if (job_q[0].op == OP_SAMPLE)
            begin
                start <= 1'b1;
                cfg_write <= 1'b0;
                sample <= job_q[0].data;
                gap_left <= job_q[0].gap;
                void'(job_q.pop_front());
            end
            else if (pixel_q.size() == 0 && !done)
            begin
                start <= 1'b0;
                cfg_write <= (job_q[0].op == OP_WRITE);
                cfg_index <= job_q[0].idx;
                cfg_data <= job_q[0].data;
                void'(job_q.pop_front());
            end
            else
            begin
                start <= 1'b0;
                cfg_write <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result r=%0d g=%0d b=%0d",
                             red_level, green_level, blue_level);
            end
            else
            begin
                pixel_t px;
                px = pixel_q.pop_front();
                if (px.red !== red_level || px.green !== green_level
                    || px.blue !== blue_level)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 px.red, px.green, px.blue,
                                 red_level, green_level, blue_level);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_write || !rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("tb_value_to_spectral_rgb_core: errors");
            $finish;
        end
    end

    initial
    begin
        longint y;
        longint k;
        longint t;
        rst_n = 1'b0;
        dense = 1'b0;

        // gamma 0.8 table, exact integer rounding
        y = 0;
        for (int i = 0; i <= ROM_LAST; i++)
        begin
            k = (longint'(i) * i * i * i) <<< 15;
            while (y < 1024)
            begin
                t = 2 * (y + 1) - 1;
                if (t * t * t * t * t <= k)
                    y++;
                else
                    break;
            end
            gamma_tab[i] = y;
        end

        // directed: reset registers, ends of the spectrum and out of band
        add_sample(16'd0);
        add_sample(16'd32767);
        add_sample(16'h8000);
        add_sample(16'hffff);
        add_sample(16'd1);
        add_sample(16'd16384);
        add_sample(16'd8000);
        add_sample(16'd24000);
        // full span, extreme gain, unused index
        add_config(16'h8000, 16'h7fff, 16'd44150, 16'd21509, 16'hffff);
        add_write(REG_UNUSED, 16'h1234);
        add_sample(16'h8000);
        add_sample(16'h7fff);
        add_sample(16'd0);
        add_sample(16'hc000);
        // zero range
        add_config(16'd100, 16'd100, 16'd44150, 16'd21509, 16'd0);
        add_sample(16'd100);
        add_sample(16'h7fff);
        // blend not positive, reversed range
        add_config(16'd1000, 16'hfc18, 16'd100, 16'hffff, 16'd256);
        add_sample(16'h8000);
        add_sample(16'h7fff);
        add_sample(16'd0);
        add_config(16'd0, 16'd10, 16'd0, 16'hffff, 16'd4095);
        add_sample(16'd5);
        add_sample(16'd10);
        add_sample(16'd0);

        // random phases
        add_config(16'd0, 16'd32767, 16'd44150, 16'd21509, 16'd256);
        add_random_run(160, 0, 32767);
        add_config(16'hf000, 16'd1000, 16'd44150, 16'd21509, 16'd700);
        add_random_run(150, -4096, 1000);
        add_config(16'd20000, 16'hd8f0, 16'd21509, 16'd44150, 16'd4095);
        add_random_run(150, -10000, 20000);
        add_config(16'd0, 16'd255, 16'd45000, 16'd20000, 16'd128);
        add_random_run(150, 0, 255);
        for (int p = 0; p < 2; p++)
        begin
            int lo;
            int hi;
            lo = $urandom_range(65535) - 32768;
            hi = $urandom_range(65535) - 32768;
            add_config(16'(lo), 16'(hi), 16'($urandom_range(38000, 50000)),
                       16'($urandom_range(18000, 26000)), 16'($urandom));
            add_random_run(150, lo, hi);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (job_q.size() == 0 && pixel_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("tb_value_to_spectral_rgb_core: clean");
        else
            $display("tb_value_to_spectral_rgb_core: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/vsrgb_pkg.sv
rtl/core/vsrgb_div.sv
rtl/core/vsrgb_band.sv
rtl/core/vsrgb_level.sv
rtl/core/value_to_spectral_rgb_core.sv
tb/tb_value_to_spectral_rgb_core.sv
